/* rtl/ott_pkg.sv */
package ott_pkg;

  // Field widths of the request and result transfers.
  localparam int KIND_W   = 2;
  localparam int PRICE_W  = 32;
  localparam int QTY_W    = 24;
  localparam int OID_W    = 32;
  localparam int FILL_W   = 25;
  localparam int STATUS_W = 3;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_PLACE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILL   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PLACED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CANCEL_NF = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PARTIAL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FILLED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FILL_NF   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic [OID_W-1:0]   order_id;
    logic [QTY_W-1:0]   fill_quantity;
  } req_t;

  typedef struct packed {
    logic [OID_W-1:0]    result_id;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   filled_total;
  } rsp_t;

endpackage

/* rtl/ott_ram.sv */
module ott_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/order_tracking_table.sv */
// Order tracking table. Each request (place, cancel or fill) is transferred
// when start is high and busy is low, and produces exactly one result, shown
// on result for one cycle with done high; kind 3 is dropped without a result.
// The receiver cannot stall, so it must take every result in the cycle that
// done is high. Every request passes through an accept step, a step that
// scales the identifier into a slot index, the synchronous table read and a
// step that modifies and writes the entry back. busy is low again in the
// cycle in which the result is shown, so a new request may be transferred
// then, but not while an earlier one is still in work. After reset the block
// holds busy high while it clears the live flag of every slot in turn.
// Orders live in slot (identifier mod ENTRIES) with the identifier kept as a
// tag; a place whose slot is still live reports busy status and does not use
// up an identifier. Identifiers count from 1 and skip 0 when they wrap.
module order_tracking_table import ott_pkg::*; #(
  parameter int ENTRIES = 256,
  parameter int ID_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  localparam int SLOT_BITS = $clog2(ENTRIES);

  // Reciprocal of the table depth for the slot reduction. With a 32-bit
  // identifier the estimated quotient is low by at most one, so a single
  // compare and subtract completes the remainder.
  localparam logic [63:0]          RECIP_WIDE = (64'd1 << 32) / 64'(ENTRIES);
  localparam logic [31:0]          RECIP      = RECIP_WIDE[31:0];
  localparam logic [SLOT_BITS:0]   DEPTH_W    = (SLOT_BITS + 1)'(ENTRIES);
  localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(ENTRIES - 1);
  localparam logic [SLOT_BITS-1:0] FIRST_SLOT = SLOT_BITS'(1 % ENTRIES);
  localparam logic [ID_BITS-1:0]   ID_ONE     = ID_BITS'(1);

  // One table entry; the live flag sits in the same word as the payload.
  typedef struct packed {
    logic               live;
    logic [ID_BITS-1:0] tag;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic [FILL_W-1:0]  filled;
  } slot_t;

  typedef enum logic [4:0] {
    CLEAR = 5'b00001,
    IDLE  = 5'b00010,
    SCALE = 5'b00100,
    LOOK  = 5'b01000,
    EXEC  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  req_t                 req_q;
  logic [31:0]          quot;
  logic [31:0]          quot_scaled;
  logic [SLOT_BITS-1:0] slot_q;
  logic [SLOT_BITS-1:0] clr_addr;
  logic [ID_BITS-1:0]   next_id;
  logic [SLOT_BITS-1:0] next_slot;

  logic [63:0]          prod;
  logic [63:0]          prod_scaled;
  logic [31:0]          diff;
  logic [SLOT_BITS:0]   diff_low;
  logic [SLOT_BITS:0]   diff_red;
  logic [SLOT_BITS-1:0] look_slot;

  logic                 ram_we;
  logic [SLOT_BITS-1:0] ram_waddr;
  slot_t                ram_wdata;
  logic [SLOT_BITS-1:0] ram_raddr;
  slot_t                entry;

  logic                 hit;
  logic [FILL_W:0]      fill_sum;
  logic [FILL_W-1:0]    fill_total;
  logic                 fill_done;
  logic                 id_advance;
  logic                 done_next;
  rsp_t                 result_next;
  logic [ID_BITS:0]     id_inc;

  assign busy = (state != IDLE);

  // Slot reduction: quotient estimate on transfer, scaled back in SCALE,
  // remainder corrected in LOOK where it also addresses the table.
  assign prod        = 64'(request.order_id) * 64'(RECIP);
  assign prod_scaled = 64'(quot) * 64'(ENTRIES);
  assign diff        = req_q.order_id - quot_scaled;
  assign diff_low    = diff[SLOT_BITS:0];
  assign diff_red    = (diff_low >= DEPTH_W) ? (diff_low - DEPTH_W) : diff_low;
  assign look_slot   = (req_q.kind == KIND_PLACE) ? next_slot
                                                  : diff_red[SLOT_BITS-1:0];
  assign ram_raddr   = look_slot;

  ott_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (entry)
  );

  // A stored tag only matches when the upper identifier bits are zero.
  assign hit        = entry.live && (req_q.order_id == OID_W'(entry.tag));
  assign fill_sum   = {1'b0, entry.filled} + (FILL_W + 1)'(req_q.fill_quantity);
  assign fill_total = fill_sum[FILL_W] ? '1 : fill_sum[FILL_W-1:0];
  assign fill_done  = (fill_total >= FILL_W'(entry.quantity));
  assign id_inc     = {1'b0, next_id} + (ID_BITS + 1)'(1);

  // Read-modify-write of the addressed entry, plus the clearing pass.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = slot_q;
    ram_wdata   = entry;
    id_advance  = 1'b0;
    done_next   = 1'b0;
    result_next = '0;
    result_next.result_id = req_q.order_id;
    if (state == CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == EXEC) begin
      case (req_q.kind)
        KIND_PLACE: begin
          done_next = 1'b1;
          result_next.result_id = OID_W'(next_id);
          if (entry.live) begin
            result_next.status = ST_BUSY;
          end else begin
            ram_we             = 1'b1;
            ram_wdata.live     = 1'b1;
            ram_wdata.tag      = next_id;
            ram_wdata.side     = req_q.side;
            ram_wdata.price    = req_q.price;
            ram_wdata.quantity = req_q.quantity;
            ram_wdata.filled   = '0;
            id_advance         = 1'b1;
            result_next.status = ST_PLACED;
          end
        end
        KIND_CANCEL: begin
          done_next = 1'b1;
          if (hit) begin
            ram_we             = 1'b1;
            ram_wdata.live     = 1'b0;
            result_next.status = ST_CANCELLED;
          end else begin
            result_next.status = ST_CANCEL_NF;
          end
        end
        KIND_FILL: begin
          done_next = 1'b1;
          if (hit) begin
            ram_we                   = 1'b1;
            ram_wdata.filled         = fill_total;
            ram_wdata.live           = !fill_done;
            result_next.filled_total = fill_total;
            result_next.status       = fill_done ? ST_FILLED : ST_PARTIAL;
          end else begin
            result_next.status = ST_FILL_NF;
          end
        end
        default: begin
          done_next = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CLEAR: begin
        if (clr_addr == LAST_SLOT) begin
          state_next = IDLE;
        end
      end
      IDLE: begin
        if (start) begin
          state_next = SCALE;
        end
      end
      SCALE: state_next = LOOK;
      LOOK:  state_next = EXEC;
      EXEC:  state_next = IDLE;
      default: state_next = CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      clr_addr  <= '0;
      next_id   <= ID_ONE;
      next_slot <= FIRST_SLOT;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == CLEAR) begin
        clr_addr <= clr_addr + SLOT_BITS'(1);
      end
      // Identifier and its slot advance together; zero is skipped on wrap.
      if (id_advance) begin
        if (id_inc[ID_BITS-1:0] == '0) begin
          next_id   <= ID_ONE;
          next_slot <= FIRST_SLOT;
        end else begin
          next_id   <= id_inc[ID_BITS-1:0];
          next_slot <= (next_slot == LAST_SLOT) ? '0 : next_slot + SLOT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == IDLE && start) begin
      req_q <= request;
      quot  <= prod[63:32];
    end
    if (state == SCALE) begin
      quot_scaled <= prod_scaled[31:0];
    end
    if (state == LOOK) begin
      slot_q <= look_slot;
    end
    result <= result_next;
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  import ott_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The table depth must match the instance, since the slot of an order is
  // its identifier modulo the depth.
  localparam int TABLE_DEPTH = 256;
  localparam int N_RANDOM    = 500;
  // Random items in the place-heavy opening stretch. Identifiers run past the
  // table depth while many early orders are still live, so places start to
  // hit occupied slots.
  localparam int N_FILLUP    = 320;
  // The last items of the run go out back to back, with no idle cycles.
  localparam int N_QUIET     = 80;
  localparam int DRAIN_LIMIT = 200;
  localparam int SETTLE      = 8;

  // Kind 3 has no meaning to the block; it is dropped without a result.
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam logic [FILL_W:0]   FILL_MAX  = 26'h1FFFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic done;
  rsp_t result;

  order_tracking_table #(
    .ENTRIES(TABLE_DEPTH),
    .ID_BITS(32)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  // Shadow of the order book. Side and price are stored by the block but
  // never show up in a result, so only what affects the result is kept.
  logic              book_live   [TABLE_DEPTH];
  logic [OID_W-1:0]  book_tag    [TABLE_DEPTH];
  logic [QTY_W-1:0]  book_qty    [TABLE_DEPTH];
  logic [FILL_W-1:0] book_filled [TABLE_DEPTH];
  logic [OID_W-1:0]  book_next_id;

  req_t order_q[$];       // requests waiting for the driver
  rsp_t pending_rsp[$];   // predicted results, oldest first
  int   bad_cnt = 0;

  // Driver state.
  req_t cur;
  logic have_cur = 1'b0;
  int   gap_left = 0;
  logic quiet = 1'b0;
  logic last_xfer = 1'b0;
  logic [127:0] junk;

  // Monitor scratch.
  rsp_t want;
  rsp_t pred;

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one request to the shadow book and returns the result it causes.
  // The return value is zero for a request that produces no result.
  function automatic bit book_apply(input req_t r, output rsp_t o);
    int               s;
    logic [OID_W-1:0] id;
    logic [FILL_W:0]  sum;
    o = '0;
    case (r.kind)
      KIND_PLACE: begin
        id = book_next_id;
        s = id % TABLE_DEPTH;
        o.result_id = id;
        if (book_live[s]) begin
          // Occupied slot: nothing changes and the identifier is not used up.
          o.status = ST_BUSY;
        end else begin
          book_live[s]   = 1'b1;
          book_tag[s]    = id;
          book_qty[s]    = r.quantity;
          book_filled[s] = '0;
          // Identifiers skip zero when they wrap.
          book_next_id   = (id == '1) ? 32'd1 : id + 32'd1;
          o.status       = ST_PLACED;
        end
        return 1'b1;
      end
      KIND_CANCEL: begin
        s = r.order_id % TABLE_DEPTH;
        o.result_id = r.order_id;
        if (book_live[s] && book_tag[s] == r.order_id) begin
          book_live[s] = 1'b0;
          o.status = ST_CANCELLED;
        end else begin
          o.status = ST_CANCEL_NF;
        end
        return 1'b1;
      end
      KIND_FILL: begin
        s = r.order_id % TABLE_DEPTH;
        o.result_id = r.order_id;
        if (book_live[s] && book_tag[s] == r.order_id) begin
          sum = {1'b0, book_filled[s]} + r.fill_quantity;
          if (sum > FILL_MAX) begin
            sum = FILL_MAX;
          end
          book_filled[s] = sum[FILL_W-1:0];
          o.filled_total = sum[FILL_W-1:0];
          // A fill that reaches the quantity completes the order; with a
          // zero quantity even a fill of zero does.
          if (sum >= {2'b00, book_qty[s]}) begin
            book_live[s] = 1'b0;
            o.status = ST_FILLED;
          end else begin
            o.status = ST_PARTIAL;
          end
        end else begin
          o.status = ST_FILL_NF;
        end
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  task automatic note_bad(input string msg);
    if (bad_cnt < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    bad_cnt++;
  endtask

  // Monitor. The block cannot be stalled, so every cycle with done high is a
  // result transfer. The check runs before the prediction of a request taken
  // at the same edge, so a result is never compared with its own request.
  always @(posedge clk) begin
    last_xfer <= !rst && start && !busy;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        note_bad($sformatf("result with nothing expected: id %h status %0d total %h",
                           result.result_id, result.status, result.filled_total));
      end else begin
        want = pending_rsp.pop_front();
        if (result.result_id !== want.result_id || result.status !== want.status ||
            result.filled_total !== want.filled_total) begin
          note_bad($sformatf({"mismatch: expected id %h status %0d total %h, ",
                              "got id %h status %0d total %h"},
                             want.result_id, want.status, want.filled_total,
                             result.result_id, result.status, result.filled_total));
        end
      end
    end
    if (!rst && start && !busy) begin
      if (book_apply(request, pred)) begin
        pending_rsp.push_back(pred);
      end
    end
  end

  // Driver. Inputs change on the falling edge. A request is offered until it
  // is transferred, but idle bursts may drop start at any point, also while a
  // request waits, and the request port then carries random noise.
  always @(negedge clk) begin
    junk = {$urandom, $urandom, $urandom, $urandom};
    if (rst) begin
      start   <= 1'b0;
      request <= junk[$bits(req_t)-1:0];
    end else begin
      if (last_xfer) begin
        have_cur = 1'b0;
      end
      if (!have_cur && order_q.size() > 0) begin
        cur = order_q.pop_front();
        have_cur = 1'b1;
      end
      if (gap_left == 0 && !quiet && have_cur && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 3);
      end
      if (have_cur && gap_left == 0) begin
        start   <= 1'b1;
        request <= cur;
      end else begin
        start   <= 1'b0;
        request <= junk[$bits(req_t)-1:0];
        if (gap_left > 0) begin
          gap_left--;
        end
      end
    end
  end

  function automatic req_t mk_req(input logic [KIND_W-1:0] k, input logic sd,
                                  input logic [PRICE_W-1:0] pr, input logic [QTY_W-1:0] q,
                                  input logic [OID_W-1:0] oid,
                                  input logic [QTY_W-1:0] fq);
    req_t r;
    r.kind          = k;
    r.side          = sd;
    r.price         = pr;
    r.quantity      = q;
    r.order_id      = oid;
    r.fill_quantity = fq;
    return r;
  endfunction

  // Keeps the request queue short, so that the random part picks its targets
  // from a book that is at most a few requests behind the block.
  task automatic push_req(input req_t r);
    while (order_q.size() >= 2) begin
      @(posedge clk);
    end
    order_q.push_back(r);
  endtask

  // Mostly small quantities so that fills complete orders, with zero, the
  // largest value and full-range values mixed in.
  function automatic logic [QTY_W-1:0] rand_qty();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return QTY_W'($urandom);
      default: return QTY_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [QTY_W-1:0] rand_fill();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return QTY_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Chooses the order that a cancel or fill names. Most of the time that is a
  // live order; otherwise it is an identifier that should miss: a random
  // one, zero, a recent one that may already be gone, or one that shares the
  // slot of a live order but not its tag. With hit_blocker set, the order
  // that occupies the slot of the next identifier is preferred, so that busy
  // slots get freed again.
  function automatic logic [OID_W-1:0] pick_target(input bit hit_blocker);
    int               first;
    int               k;
    int               s;
    logic [OID_W-1:0] live_id;
    live_id = book_next_id - 32'd1;
    first = $urandom_range(0, TABLE_DEPTH - 1);
    for (k = 0; k < TABLE_DEPTH; k++) begin
      s = (first + k) % TABLE_DEPTH;
      if (book_live[s]) begin
        live_id = book_tag[s];
        break;
      end
    end
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 3))
        0: return $urandom;
        1: return '0;
        2: return book_next_id - 32'($urandom_range(1, 8));
        default: return live_id + 32'(TABLE_DEPTH);
      endcase
    end
    s = book_next_id % TABLE_DEPTH;
    if (hit_blocker && book_live[s] && $urandom_range(0, 99) < 30) begin
      return book_tag[s];
    end
    return live_id;
  endfunction

  initial begin
    int               n;
    int               pick;
    int               waited;
    bit               fillup;
    req_t             r;

    for (n = 0; n < TABLE_DEPTH; n++) begin
      book_live[n]   = 1'b0;
      book_tag[n]    = '0;
      book_qty[n]    = '0;
      book_filled[n] = '0;
    end
    book_next_id = 32'd1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Identifiers run 1, 2, ... from reset, so the targets
    // are known here.
    // Zero quantity and zero price: the first fill, even of zero, completes it.
    push_req(mk_req(KIND_PLACE, 1'b0, 32'h0, 24'h0, 32'h0, 24'h0));
    // Largest price and quantity on the sell side.
    push_req(mk_req(KIND_PLACE, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'h0, 24'h0));
    push_req(mk_req(KIND_FILL, 1'b0, 32'h0, 24'h0, 32'd1, 24'h0));
    // Partial fill just short of the quantity, then a largest fill that takes
    // the count far past it and into the top bit of the total.
    push_req(mk_req(KIND_FILL, 1'b0, 32'h0, 24'h0, 32'd2, 24'hFF_FFFE));
    push_req(mk_req(KIND_FILL, 1'b1, 32'h0, 24'h0, 32'd2, 24'hFF_FFFF));
    // The filled order is gone.
    push_req(mk_req(KIND_CANCEL, 1'b0, 32'h0, 24'h0, 32'd2, 24'h0));
    // Place, part fill, cancel, then cancel and fill of the removed order.
    push_req(mk_req(KIND_PLACE, 1'b0, 32'h1234_5678, 24'd5, 32'h0, 24'h0));
    push_req(mk_req(KIND_FILL, 1'b0, 32'h0, 24'h0, 32'd3, 24'd2));
    push_req(mk_req(KIND_CANCEL, 1'b0, 32'h0, 24'h0, 32'd3, 24'h0));
    push_req(mk_req(KIND_CANCEL, 1'b0, 32'h0, 24'h0, 32'd3, 24'h0));
    push_req(mk_req(KIND_FILL, 1'b0, 32'h0, 24'h0, 32'd3, 24'd1));
    // A live order, then requests that land on its slot with another tag.
    push_req(mk_req(KIND_PLACE, 1'b1, 32'h8000_0001, 24'd7, 32'h0, 24'h0));
    push_req(mk_req(KIND_CANCEL, 1'b0, 32'h0, 24'h0, 32'd4 + TABLE_DEPTH, 24'h0));
    push_req(mk_req(KIND_FILL, 1'b0, 32'h0, 24'h0, 32'd4 + TABLE_DEPTH, 24'd7));
    // Identifier zero is never assigned; all ones is never live here.
    push_req(mk_req(KIND_CANCEL, 1'b0, 32'h0, 24'h0, 32'h0, 24'h0));
    push_req(mk_req(KIND_FILL, 1'b0, 32'h0, 24'h0, 32'hFFFF_FFFF, 24'hFF_FFFF));
    // Unknown kind aimed at a live order: no result and no effect.
    push_req(mk_req(KIND_NONE, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'd4, 24'hFF_FFFF));
    // A fill of exactly the quantity completes the order.
    push_req(mk_req(KIND_FILL, 1'b0, 32'h0, 24'h0, 32'd4, 24'd7));
    // Quantity one with the largest fill.
    push_req(mk_req(KIND_PLACE, 1'b0, 32'h0000_FFFF, 24'd1, 32'h0, 24'h0));
    push_req(mk_req(KIND_FILL, 1'b0, 32'h0, 24'h0, 32'd5, 24'hFF_FFFF));

    // Random part. The opening stretch is mostly places, which fills the book
    // until places run into occupied slots; after that the mix favors fills
    // and cancels, aimed mostly at live orders.
    for (n = 0; n < N_RANDOM; n++) begin
      fillup = (n < N_FILLUP);
      quiet  = (n >= N_RANDOM - N_QUIET);
      r.side          = 1'($urandom);
      r.price         = $urandom;
      r.quantity      = rand_qty();
      r.order_id      = $urandom;
      r.fill_quantity = rand_fill();
      pick = $urandom_range(0, 99);
      if (pick < (fillup ? 80 : 35)) begin
        r.kind = KIND_PLACE;
      end else if (pick < (fillup ? 88 : 55)) begin
        r.kind = KIND_CANCEL;
        r.order_id = pick_target(!fillup);
      end else if (pick < 96) begin
        r.kind = KIND_FILL;
        r.order_id = pick_target(!fillup);
      end else begin
        r.kind = KIND_NONE;
      end
      push_req(r);
    end

    // Wait until the last request has been transferred, then for the
    // outstanding results, then wait out the SETTLE period for anything stray.
    while (order_q.size() > 0 || have_cur) begin
      @(posedge clk);
    end
    waited = 0;
    while (pending_rsp.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (pending_rsp.size() > 0) begin
      want = pending_rsp.pop_front();
      note_bad($sformatf("missing result: expected id %h status %0d total %h",
                         want.result_id, want.status, want.filled_total));
    end
    repeat (SETTLE) @(posedge clk);

    if (bad_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // A correct run takes well under 100 us including the clearing pass.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
